### design/sequence_tagged_ring_lookup_top_defines.svh
// Assertion macros used by the top level of the sequence-tagged ring lookup design.
`ifndef SEQUENCE_TAGGED_RING_LOOKUP_TOP_DEFINES_SVH
`define SEQUENCE_TAGGED_RING_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define STLR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STLR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/stlr_pkg.sv
// Package with types, codes and constants of the sequence-tagged ring lookup.
`default_nettype none

package stlr_pkg;

   // Default number of slots; must be a power of two.
   localparam int unsigned STLR_DEPTH = 1024;

   localparam int unsigned SEQ_W = 64;
   localparam int unsigned POS_W = 64;
   localparam int unsigned STATUS_W = 3;

   typedef logic [STATUS_W-1:0] status_type;

   // Lookup status codes.
   localparam status_type ST_HIT         = 3'd0;
   localparam status_type ST_OVERWRITTEN = 3'd1;
   localparam status_type ST_NOT_SENT    = 3'd2;
   localparam status_type ST_EMPTY       = 3'd3;
   localparam status_type ST_LAPPED      = 3'd4;

   // Operation codes.
   localparam logic OP_STORE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // One slot of the ring memory.
   typedef struct packed {
      logic [SEQ_W-1:0] tag;
      logic [POS_W-1:0] position;
   } slot_type;

   // Lookup in flight: the number and the misses already known at acceptance.
   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic             overwritten;
      logic             not_sent;
      logic             empty;
   } lookup_type;

endpackage

`default_nettype wire

### design/stlr_slot_mem.sv
// Single-port slot memory with a registered read port.
`default_nettype none

module stlr_slot_mem
   import stlr_pkg::*;
#(
   parameter int unsigned DEPTH = STLR_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire slot_type                 wr_data,
   output slot_type                      rd_data
);

   slot_type slot_mem_ff [DEPTH];
   slot_type rd_data_ff;

   // Write and read share one address; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/stlr_status.sv
// Final status decision and the result output register.
`default_nettype none

module stlr_status
   import stlr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             lk_valid,
   input  wire lookup_type       lk,
   input  wire slot_type         rd_data,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output status_type            rsp_status,
   output logic [POS_W-1:0]      rsp_found_position
);

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   status_type       status_ff;
   status_type       status_in;
   logic [POS_W-1:0] found_ff;
   logic [POS_W-1:0] found_in;
   logic             advance;

   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign advance  = lk_valid & out_free;

   // Misses in priority order; the tag compare is the only one left for this cycle.
   always_comb begin
      status_in = ST_HIT;
      found_in  = rd_data.position;
      if (lk.overwritten) begin
         status_in = ST_OVERWRITTEN;
      end else if (lk.not_sent) begin
         status_in = ST_NOT_SENT;
      end else if (lk.empty) begin
         status_in = ST_EMPTY;
      end else if (rd_data.tag != lk.seq) begin
         status_in = ST_LAPPED;
      end
      if (status_in != ST_HIT) begin
         found_in = '0;
      end
   end

   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   // Output valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload loads only when a new result moves in.
   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = found_ff;

endmodule

`default_nettype wire

### design/sequence_tagged_ring_lookup_top.sv
// A lookup result is registered in the held-lookup stage and the memory read port, then in the output register.
// A store produces no result and completes in the cycle of its transfer.
// Throughput: one item per cycle unless stalled, set by the single port of the slot memory.
// Reset: a clearing pass of DEPTH cycles writes zero to every slot while
// req_ready stays low; the newest number and all handshake state reset at once.
`default_nettype none

`include "sequence_tagged_ring_lookup_top_defines.svh"

module sequence_tagged_ring_lookup_top
   import stlr_pkg::*;
#(
   parameter int unsigned DEPTH = STLR_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_opcode,
   input  wire logic [SEQ_W-1:0] req_seq_number,
   input  wire logic [POS_W-1:0] req_record_position,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output status_type            rsp_status,
   output logic [POS_W-1:0]      rsp_found_position
);

   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam logic [SEQ_W-1:0] DEPTH_SEQ = SEQ_W'(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic              clear_ff;
   logic              clear_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic [SEQ_W-1:0]  newest_ff;
   logic [SEQ_W-1:0]  floor_ff;
   logic              deep_ff;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   lookup_type        s1_ff;
   lookup_type        s1_in;
   logic              out_free;
   logic              accept;
   logic              accept_store;
   logic              accept_lookup;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_addr;
   slot_type          mem_wr_data;
   slot_type          mem_rd_data;

   // Input side stalls while clearing or while the held lookup cannot move on.
   assign req_ready     = ~clear_ff & (~s1_valid_ff | out_free);
   assign accept        = req_valid & req_ready;
   assign accept_store  = accept & (req_opcode == OP_STORE);
   assign accept_lookup = accept & (req_opcode == OP_LOOKUP);

   // Clearing pass after reset, one slot per cycle.
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Newest number, with its DEPTH-below floor prepared at store time.
   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= '0;
         floor_ff  <= '0;
         deep_ff   <= 1'b0;
      end else if (accept_store) begin
         newest_ff <= req_seq_number;
         floor_ff  <= req_seq_number - DEPTH_SEQ;
         deep_ff   <= req_seq_number >= DEPTH_SEQ;
      end
   end

   // Misses that depend only on the newest number are settled at transfer.
   always_comb begin
      s1_in.seq         = req_seq_number;
      s1_in.overwritten = deep_ff & (req_seq_number <= floor_ff);
      s1_in.not_sent    = req_seq_number > newest_ff;
      s1_in.empty       = newest_ff == '0;
   end

   assign s1_valid_in = accept_lookup | (s1_valid_ff & ~out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_lookup) begin
         s1_ff <= s1_in;
      end
   end

   // Memory port: clearing, store writes and lookup reads never coincide.
   // A store followed by a lookup of the same slot reads the new data, and a
   // lookup followed by a store keeps the data already registered.
   assign mem_wr_en = clear_ff | accept_store;
   assign mem_addr  = clear_ff ? clr_addr_ff : req_seq_number[ADDR_W-1:0];

   always_comb begin
      mem_wr_data.tag      = req_seq_number;
      mem_wr_data.position = req_record_position;
      if (clear_ff) begin
         mem_wr_data = '0;
      end
   end

   stlr_slot_mem #(
      .DEPTH (DEPTH)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (accept_lookup),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   stlr_status u_status (
      .clock              (clock),
      .reset              (reset),
      .lk_valid           (s1_valid_ff),
      .lk                 (s1_ff),
      .rd_data            (mem_rd_data),
      .out_free           (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position)
   );

   // No transfer is taken while the clearing pass runs.
   `STLR_ASSERT_NOW(a_no_accept_in_clear, clear_ff, !req_ready, "transfer during clearing pass")

   // A lookup transfer always lands in the stage that waits for the memory data.
   `STLR_ASSERT_NEXT(a_lookup_enters_s1, accept_lookup, s1_valid_ff, "lookup lost after transfer")

   // A held lookup keeps its contents while the output register is blocked.
   `STLR_ASSERT_NEXT(a_s1_holds, s1_valid_ff && !out_free, s1_valid_ff && $stable(s1_ff),
      "held lookup changed while stalled")

   // Every miss carries a zero position.
   `STLR_ASSERT_NOW(a_miss_zero_pos, rsp_valid && (rsp_status != ST_HIT),
      rsp_found_position == '0, "miss with nonzero position")

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench of the sequence-tagged ring lookup with directed and random traffic.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import stlr_pkg::*;

   localparam int unsigned RING_DEPTH = STLR_DEPTH;
   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

   // Answer expected for one lookup.
   typedef struct {
      status_type       status;
      logic [POS_W-1:0] position;
   } lookup_answer_type;

   // Tracks the ring contents and the queue of lookup answers still owed by the block.
   class lookup_scoreboard;
      bit [SEQ_W-1:0] slot_tags [RING_DEPTH];
      bit [POS_W-1:0] slot_positions [RING_DEPTH];
      bit [SEQ_W-1:0] newest;
      lookup_answer_type answers_due [$];
      int unsigned    failures;

      // Updates the ring on a store, or queues the answer of a lookup.
      function void note_transfer(logic op, logic [SEQ_W-1:0] seq, logic [POS_W-1:0] pos);
         int unsigned       slot;
         lookup_answer_type answer;
         slot = int'(seq % RING_DEPTH);
         if (op == OP_STORE) begin
            slot_tags[slot] = seq;
            slot_positions[slot] = pos;
            newest = seq;
         end else begin
            answer.position = '0;
            // The sum seq + DEPTH is formed in 65 bits so that it never wraps.
            if (({1'b0, seq} + RING_DEPTH) <= {1'b0, newest}) begin
               answer.status = ST_OVERWRITTEN;
            end else if (seq > newest) begin
               answer.status = ST_NOT_SENT;
            end else if (newest == '0) begin
               answer.status = ST_EMPTY;
            end else if (slot_tags[slot] != seq) begin
               answer.status = ST_LAPPED;
            end else begin
               answer.status = ST_HIT;
               answer.position = slot_positions[slot];
            end
            answers_due.push_back(answer);
         end
      endfunction

      // Compares one result transfer with the oldest answer due.
      function void check_result(status_type status, logic [POS_W-1:0] position);
         lookup_answer_type answer;
         if (answers_due.size() == 0) begin
            $display("%0t: result with nothing due: status %0d position %h",
                     $realtime, status, position);
            failures++;
         end else begin
            answer = answers_due.pop_front();
            if (status !== answer.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $realtime, answer.status, status);
               failures++;
            end
            if (position !== answer.position) begin
               $display("%0t: position mismatch: expected %h, actual %h",
                        $realtime, answer.position, position);
               failures++;
            end
         end
      endfunction

      function int unsigned pending();
         return answers_due.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_opcode = OP_STORE;
   logic [SEQ_W-1:0] req_seq_number = '0;
   logic [POS_W-1:0] req_record_position = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   status_type       rsp_status;
   logic [POS_W-1:0] rsp_found_position;

   int unsigned      idle_pct = 0;
   int unsigned      stall_pct = 0;
   logic [SEQ_W-1:0] seq_cursor = '0;

   lookup_scoreboard sb = new;

   sequence_tagged_ring_lookup_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_seq_number     (req_seq_number),
      .req_record_position(req_record_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position)
   );

   always #1 clock = ~clock;

   // The result side stalls at random at the current rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Every result transfer is checked against the oldest answer due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_status, rsp_found_position);
      end
   end

   // Offers one item after a random idle gap and holds it until its transfer.
   task automatic send_item(logic op, logic [SEQ_W-1:0] seq, logic [POS_W-1:0] pos);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_seq_number <= seq;
      req_record_position <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_transfer(op, seq, pos);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly an advancing stream of stores with lookups around its head; some noise.
   task automatic send_random_item();
      int unsigned      pick;
      logic [SEQ_W-1:0] seq;
      pick = $urandom_range(99);
      if (pick < 40) begin
         if (pick < 2) begin
            seq_cursor = random_word();
            seq = seq_cursor;
         end else if (pick < 3) begin
            seq_cursor = {32'hFFFF_FFFF, $urandom};
            seq = seq_cursor;
         end else if (pick < 5) begin
            // Store below the head; the head stays, the newest number moves back with it.
            seq = seq_cursor - $urandom_range(0, 2000);
         end else begin
            seq_cursor = seq_cursor + $urandom_range(1, 3);
            seq = seq_cursor;
         end
         send_item(OP_STORE, seq, random_word());
      end else begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            seq = seq_cursor - $urandom_range(0, 1100);
         end else if (pick < 82) begin
            seq = seq_cursor + $urandom_range(1, 5);
         end else if (pick < 95) begin
            seq = random_word();
         end else begin
            seq = '0;
         end
         send_item(OP_LOOKUP, seq, random_word());
      end
   endtask

   // Directed part, random phases with different idle and stall rates, then drain.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty store: zero reads empty, anything else not yet sent.
      send_item(OP_LOOKUP, 64'd0, 64'd0);
      send_item(OP_LOOKUP, 64'd5, SEQ_MAX);
      send_item(OP_LOOKUP, SEQ_MAX, 64'd0);
      send_item(OP_STORE, 64'd1, SEQ_MAX);
      send_item(OP_LOOKUP, 64'd1, 64'd0);
      // Zero matches the cleared tag of its slot.
      send_item(OP_LOOKUP, 64'd0, 64'd0);
      send_item(OP_LOOKUP, 64'd2, 64'd0);
      send_item(OP_STORE, 64'd1025, 64'hA5A5_5A5A_F00F_0FF0);
      send_item(OP_LOOKUP, 64'd1, 64'd0);
      send_item(OP_LOOKUP, 64'd1025, 64'd0);
      send_item(OP_LOOKUP, 64'd2, 64'd0);
      // Top of the number range, where the sum with DEPTH would wrap.
      send_item(OP_STORE, SEQ_MAX, 64'd0);
      send_item(OP_LOOKUP, SEQ_MAX, 64'd0);
      send_item(OP_LOOKUP, SEQ_MAX - 64'd1024, 64'd0);
      send_item(OP_LOOKUP, SEQ_MAX - 64'd1023, 64'd0);
      // A store below the newest number still becomes the newest.
      send_item(OP_STORE, 64'd3, 64'h8000_0000_0000_0001);
      send_item(OP_LOOKUP, 64'd1025, 64'd0);
      send_item(OP_LOOKUP, 64'd3, 64'd0);
      send_item(OP_STORE, 64'd0, 64'h0123_4567_89AB_CDEF);
      send_item(OP_LOOKUP, 64'd0, 64'd0);
      send_item(OP_LOOKUP, 64'd1, 64'd0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 68; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         repeat (100) send_random_item();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #200000;
      $display("tb_top failed");
      $finish;
   end

endmodule

`default_nettype wire
